// ===== hdl/swm_pkg.sv =====
// Shared types, constants and helper functions for the swerve module command block.
`timescale 1ns / 1ps
package swm_pkg;

  localparam int WHEEL_COUNT  = 4;
  localparam int CORDIC_STEPS = 30;

  localparam int WV_W  = 38;  // wheel velocity, Q16.16 with headroom
  localparam int CX_W  = 60;  // CORDIC x/y working width
  localparam int CZ_W  = 35;  // CORDIC angle, Q30 radians
  localparam int ANG_W = 36;  // angle units before storing
  localparam int MAG_W = 40;
  localparam int MA_W  = 41;  // multiplier operand a
  localparam int MB_W  = 17;  // multiplier operand b
  localparam int PR_W  = 58;  // product
  localparam int ACC_W = 74;

  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CZ_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam longint HALF_PI_Q30_L = 64'sd1686629713;

  // 1/gain in Q24, split into 16-bit halves
  localparam logic [15:0] INV_GAIN_LO = 16'd29934;
  localparam logic [15:0] INV_GAIN_HI = 16'd155;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_LEVER0 = 3'd1;
  localparam logic [2:0] REG_LEVER3 = 3'd4;
  localparam logic [2:0] REG_SPEED  = 3'd5;
  localparam logic [2:0] REG_ANGLE  = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MLX, ST_MLY, ST_WY, ST_CINIT, ST_CORD,
    ST_G0, ST_G1, ST_G2, ST_UNW, ST_FLP,
    ST_D0, ST_D1, ST_D2, ST_A0, ST_A1, ST_A2, ST_DONE
  } st_e;

  typedef struct packed {
    logic                   done;
    logic [MAG_W-1:0]       mag_raw;  // x >> 20 after the last rotation
    logic signed [CZ_W-1:0] z;        // heading, exact axes already applied
  } cord_res_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'h3243F6A8;
      5'd1:  r = 30'h1DAC6705;
      5'd2:  r = 30'h0FADBAFC;
      5'd3:  r = 30'h07F56EA6;
      5'd4:  r = 30'h03FEAB76;
      5'd5:  r = 30'h01FFD55B;
      5'd6:  r = 30'h00FFFAAA;
      5'd7:  r = 30'h007FFF55;
      5'd8:  r = 30'h003FFFEA;
      5'd9:  r = 30'h001FFFFD;
      5'd10: r = 30'h000FFFFF;
      5'd11: r = 30'h0007FFFF;
      5'd12: r = 30'h0003FFFF;
      5'd13: r = 30'h0001FFFF;
      5'd14: r = 30'h0000FFFF;
      5'd15: r = 30'h00007FFF;
      5'd16: r = 30'h00003FFF;
      5'd17: r = 30'h00001FFF;
      5'd18: r = 30'h00000FFF;
      5'd19: r = 30'h000007FF;
      5'd20: r = 30'h000003FF;
      5'd21: r = 30'h000001FF;
      5'd22: r = 30'h000000FF;
      5'd23: r = 30'h0000007F;
      5'd24: r = 30'h0000003F;
      5'd25: r = 30'h0000001F;
      5'd26: r = 30'h0000000F;
      5'd27: r = 30'h00000008;
      5'd28: r = 30'h00000004;
      5'd29: r = 30'h00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

  // k quarter turns (k * pi/2) in angle units, rounded
  function automatic logic signed [ANG_W-1:0] halves(input int k, input int afb);
    logic signed [63:0] t;
    int sh;
    sh = 30 - afb;
    t  = 64'(k) * HALF_PI_Q30_L;
    t  = (t + (64'sd1 <<< (sh - 1))) >>> sh;
    return t[ANG_W-1:0];
  endfunction

  function automatic logic [31:0] sat_out(input logic neg, input logic [ACC_W-1:0] r);
    logic [31:0] v;
    if (neg) begin
      v = (r > ACC_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-r);
    end else begin
      v = (r > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r[31:0];
    end
    return v;
  endfunction

  function automatic logic [31:0] sat_store(input logic signed [ANG_W-1:0] a);
    logic [31:0] v;
    if (a > ANG_W'(64'sh7FFF_FFFF)) v = 32'h7FFF_FFFF;
    else if (a < -ANG_W'(64'sh8000_0000)) v = 32'h8000_0000;
    else v = a[31:0];
    return v;
  endfunction

endpackage

// ===== hdl/swm_if.sv =====
// Valid/ready channel interfaces for commands and wheel results.
`timescale 1ns / 1ps
interface swm_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cmd_vx;
  logic signed [31:0] cmd_vy;
  logic signed [31:0] cmd_yaw;

  modport source (output valid, cmd_vx, cmd_vy, cmd_yaw, input ready);
  modport sink (input valid, cmd_vx, cmd_vy, cmd_yaw, output ready);
endinterface

interface swm_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_rot0;
  logic signed [31:0] drive_rot1;
  logic signed [31:0] drive_rot2;
  logic signed [31:0] drive_rot3;
  logic signed [31:0] steer_rot0;
  logic signed [31:0] steer_rot1;
  logic signed [31:0] steer_rot2;
  logic signed [31:0] steer_rot3;
  logic [3:0]         window_lost;

  modport source (output valid, drive_rot0, drive_rot1, drive_rot2, drive_rot3,
                  steer_rot0, steer_rot1, steer_rot2, steer_rot3, window_lost,
                  input ready);
  modport sink (input valid, drive_rot0, drive_rot1, drive_rot2, drive_rot3,
                steer_rot0, steer_rot1, steer_rot2, steer_rot3, window_lost,
                output ready);
endinterface

// ===== hdl/swm_cordic.sv =====
// Iterative vectoring CORDIC: one rotation per cycle, heading and scaled magnitude.
`timescale 1ns / 1ps
module swm_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [swm_pkg::WV_W-1:0]   x0_i,
  input  logic signed [swm_pkg::WV_W-1:0]   y0_i,
  output swm_pkg::cord_res_t                res_o
);

  logic signed [swm_pkg::CX_W-1:0] x_q, y_q, xs, ys, dx, dy;
  logic signed [swm_pkg::CZ_W-1:0] z_q, at;
  logic [4:0] it_q;
  logic busy_q, done_q;
  logic xz_q, yz_q, xp_q, yp_q;

  assign xs = {{2{x0_i[swm_pkg::WV_W-1]}}, x0_i, 20'b0};
  assign ys = {{2{y0_i[swm_pkg::WV_W-1]}}, y0_i, 20'b0};
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign at = {5'b0, swm_pkg::atan_q30(it_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        it_q <= it_q + 5'd1;
        if (it_q == 5'(swm_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xz_q <= (x0_i == '0);
      yz_q <= (y0_i == '0);
      xp_q <= !x0_i[swm_pkg::WV_W-1] && (x0_i != '0);
      yp_q <= !y0_i[swm_pkg::WV_W-1] && (y0_i != '0);
      // fold the left half-plane over before rotating
      if (x0_i[swm_pkg::WV_W-1]) begin
        x_q <= -xs;
        y_q <= -ys;
        z_q <= y0_i[swm_pkg::WV_W-1] ? -swm_pkg::PI_Q30 : swm_pkg::PI_Q30;
      end else begin
        x_q <= xs;
        y_q <= ys;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[swm_pkg::CX_W-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end
    end
  end

  always_comb begin
    res_o.done    = done_q;
    res_o.mag_raw = x_q[swm_pkg::CX_W-1:20];
    if (yz_q) res_o.z = xp_q ? '0 : swm_pkg::PI_Q30;
    else if (xz_q) res_o.z = yp_q ? swm_pkg::HALF_PI_Q30 : -swm_pkg::HALF_PI_Q30;
    else res_o.z = z_q;
  end

endmodule

// ===== hdl/swerve_module_command_top.sv =====
// Top level: swerve inverse kinematics sequencer around a shared multiplier and CORDIC.
`timescale 1ns / 1ps
// Usage
//  cmd_i : one beat carries a body velocity command (vx, vy, yaw rate).
//  res_o : one beat per command with drive and steer for all four wheels and
//          the window_lost flags.
//  cfg   : cfg_we_i writes cfg_data_i into register cfg_idx_i;
//          write only while no command is in flight.
// Sequencing: the wheels are worked one after another. A wheel with nonzero
//  velocity runs the 30-step CORDIC and eight passes through the one shared
//  41x17 multiplier; a wheel at zero velocity skips the CORDIC and the gain
//  correction. cmd_i.ready is low from accept until the result is written
//  to the output register.
// The finished result sits in an output register: a new command is accepted
//  while it waits, and a stalled receiver only holds the block once the next
//  result is ready to be written.
// Reset: all configuration goes to its reset values, stored steer angles to
//  zero, and no result is pending.
module swerve_module_command_top #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  swm_cmd_if.sink       cmd_i,
  swm_res_if.source     res_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int AW = swm_pkg::ANG_W;
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam int RSH = ANGLE_FRAC_BITS + 8;
  localparam logic signed [AW-1:0] ROUND = AW'(1) << (SH - 1);
  localparam logic signed [AW-1:0] H1 = swm_pkg::halves(1, ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] H2 = swm_pkg::halves(2, ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] H3 = swm_pkg::halves(3, ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] H4 = swm_pkg::halves(4, ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] H5 = swm_pkg::halves(5, ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] H6 = swm_pkg::halves(6, ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] H7 = swm_pkg::halves(7, ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] H8 = swm_pkg::halves(8, ANGLE_FRAC_BITS);

  swm_pkg::st_e state_q, state_d;
  logic [1:0]   wheel_q;
  logic         out_valid_q;

  logic        mode_q;
  logic [31:0] lever_q [swm_pkg::WHEEL_COUNT];
  logic [31:0] sscale_q, ascale_q;
  logic [31:0] steer_q [swm_pkg::WHEEL_COUNT];

  logic signed [31:0] vx_q, vy_q, yaw_q;
  logic signed [swm_pkg::WV_W-1:0] wx_q, wy_q;
  logic signed [swm_pkg::PR_W-1:0] prod_q, prod_d;
  logic [swm_pkg::ACC_W-1:0] acc_q, acc_sum;
  logic [swm_pkg::MAG_W-1:0] mag_q;
  logic signed [AW-1:0] c_q, s_q;
  logic zero_q, flag_q, flip_q;
  logic [31:0] drive_q [swm_pkg::WHEEL_COUNT];
  logic [31:0] srot_q [swm_pkg::WHEEL_COUNT];
  logic [3:0]  lost_q;

  logic [31:0] out_drive_q [swm_pkg::WHEEL_COUNT];
  logic [31:0] out_steer_q [swm_pkg::WHEEL_COUNT];
  logic [3:0]  out_lost_q;

  logic signed [swm_pkg::MA_W-1:0] mul_a;
  logic signed [swm_pkg::MB_W-1:0] mul_b;
  logic signed [45:0] lev_term, w_sum;
  logic [15:0] lx, ly;
  logic cord_start, load_out;
  swm_pkg::cord_res_t cord;
  logic signed [AW-1:0] z_ext, z_rnd, c_ang;
  logic signed [AW-1:0] c_unw, c_flp, a_rot, a_abs;
  logic signed [AW:0]   d_cs;
  logic flag_unw, flip_d;

  swm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x0_i    (wx_q),
    .y0_i    (wy_q),
    .res_o   (cord)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= swm_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cord_start = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      swm_pkg::ST_IDLE:  if (cmd_i.valid) state_d = swm_pkg::ST_MLX;
      swm_pkg::ST_MLX:   state_d = swm_pkg::ST_MLY;
      swm_pkg::ST_MLY:   state_d = swm_pkg::ST_WY;
      swm_pkg::ST_WY:    state_d = swm_pkg::ST_CINIT;
      swm_pkg::ST_CINIT: begin
        if (wx_q == '0 && wy_q == '0) begin
          state_d = swm_pkg::ST_UNW;
        end else begin
          cord_start = 1'b1;
          state_d    = swm_pkg::ST_CORD;
        end
      end
      swm_pkg::ST_CORD:  if (cord.done) state_d = swm_pkg::ST_G0;
      swm_pkg::ST_G0:    state_d = swm_pkg::ST_G1;
      swm_pkg::ST_G1:    state_d = swm_pkg::ST_G2;
      swm_pkg::ST_G2:    state_d = swm_pkg::ST_UNW;
      swm_pkg::ST_UNW:   state_d = swm_pkg::ST_FLP;
      swm_pkg::ST_FLP:   state_d = swm_pkg::ST_D0;
      swm_pkg::ST_D0:    state_d = swm_pkg::ST_D1;
      swm_pkg::ST_D1:    state_d = swm_pkg::ST_D2;
      swm_pkg::ST_D2:    state_d = swm_pkg::ST_A0;
      swm_pkg::ST_A0:    state_d = swm_pkg::ST_A1;
      swm_pkg::ST_A1:    state_d = swm_pkg::ST_A2;
      swm_pkg::ST_A2: begin
        state_d = (wheel_q == 2'(swm_pkg::WHEEL_COUNT - 1)) ? swm_pkg::ST_DONE
                                                            : swm_pkg::ST_MLX;
      end
      swm_pkg::ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = swm_pkg::ST_IDLE;
        end
      end
      default: state_d = swm_pkg::ST_IDLE;
    endcase
  end

  assign cmd_i.ready = (state_q == swm_pkg::ST_IDLE);

  // ---------------- shared multiplier ----------------
  assign lx = lever_q[wheel_q][31:16];
  assign ly = lever_q[wheel_q][15:0];
  assign a_rot = zero_q ? s_q : c_q;
  assign a_abs = a_rot[AW-1] ? -a_rot : a_rot;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      swm_pkg::ST_MLX: begin
        mul_a = {{9{yaw_q[31]}}, yaw_q};
        mul_b = {lx[15], lx};
      end
      swm_pkg::ST_MLY: begin
        mul_a = {{9{yaw_q[31]}}, yaw_q};
        mul_b = {ly[15], ly};
      end
      swm_pkg::ST_G0: begin
        mul_a = {1'b0, cord.mag_raw};
        mul_b = {1'b0, swm_pkg::INV_GAIN_LO};
      end
      swm_pkg::ST_G1: begin
        mul_a = {1'b0, cord.mag_raw};
        mul_b = {1'b0, swm_pkg::INV_GAIN_HI};
      end
      swm_pkg::ST_D0: begin
        mul_a = {1'b0, mag_q};
        mul_b = {1'b0, sscale_q[15:0]};
      end
      swm_pkg::ST_D1: begin
        mul_a = {1'b0, mag_q};
        mul_b = {1'b0, sscale_q[31:16]};
      end
      swm_pkg::ST_A0: begin
        mul_a = {5'b0, a_abs};
        mul_b = {1'b0, ascale_q[15:0]};
      end
      swm_pkg::ST_A1: begin
        mul_a = {5'b0, a_abs};
        mul_b = {1'b0, ascale_q[31:16]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign lev_term = prod_q[swm_pkg::PR_W-1:12];
  assign w_sum    = lev_term + {{14{(state_q == swm_pkg::ST_MLY) ? vx_q[31] : vy_q[31]}},
                                (state_q == swm_pkg::ST_MLY) ? vx_q : vy_q};
  // high partial product lands 16 bits up
  assign acc_sum  = acc_q + {prod_q[swm_pkg::PR_W-1:0], 16'b0};

  // ---------------- heading and unwrap ----------------
  assign z_ext = {cord.z[swm_pkg::CZ_W-1], cord.z};
  assign z_rnd = z_ext + ROUND;
  assign c_ang = z_rnd >>> SH;

  always_comb begin
    c_unw    = c_q;
    flag_unw = 1'b1;
    if (!mode_q) begin
      if (c_q > 0) begin
        if (-H8 < s_q && s_q < -H5) c_unw = c_q - H8;
        else if (-H5 <= s_q && s_q < -H1) c_unw = c_q - H4;
        else if (-H1 <= s_q && s_q < H3) begin
          c_unw = c_q;
        end
        else if (H3 <= s_q && s_q < H7) c_unw = c_q + H4;
        else flag_unw = 1'b0;
      end else if (c_q < 0) begin
        if (-H7 < s_q && s_q < -H3) c_unw = c_q - H4;
        else if (s_q < H1) begin
          if (s_q < -H4) flag_unw = 1'b0;
        end
        else if (s_q < H5) c_unw = c_q + H4;
        else if (s_q < H8) c_unw = c_q + H8;
        else flag_unw = 1'b0;
      end else begin
        if (-H6 < s_q && s_q < -H2) c_unw = -H4;
        else if (s_q < H2) c_unw = '0;
        else if (s_q < H6) c_unw = H4;
        else begin
          c_unw    = '0;
          flag_unw = 1'b0;
        end
      end
    end else begin
      if (s_q > H1 && c_q < 0) c_unw = c_q + H4;
      else if (s_q < -H1 && c_q > 0) c_unw = c_q - H4;
    end
  end

  // on a tracked heading, turn the other way and reverse the drive when the turn exceeds a quarter
  assign d_cs = c_q - s_q;
  always_comb begin
    c_flp  = c_q;
    flip_d = 1'b0;
    if (flag_q) begin
      if (d_cs > H1) begin
        c_flp  = c_q - H2;
        flip_d = 1'b1;
      end else if (d_cs < -H1) begin
        c_flp  = c_q + H2;
        flip_d = 1'b1;
      end
    end
  end

  // ---------------- control and configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q     <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      sscale_q    <= 32'd16777216;
      ascale_q    <= 32'd16777216;
      for (int i = 0; i < swm_pkg::WHEEL_COUNT; i++) begin
        lever_q[i] <= '0;
        steer_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          swm_pkg::REG_MODE:  mode_q   <= cfg_data_i[0];
          swm_pkg::REG_SPEED: sscale_q <= cfg_data_i;
          swm_pkg::REG_ANGLE: ascale_q <= cfg_data_i;
          default: begin
            if (cfg_idx_i inside {[swm_pkg::REG_LEVER0:swm_pkg::REG_LEVER3]}) begin
              lever_q[2'(cfg_idx_i - swm_pkg::REG_LEVER0)] <= cfg_data_i;
            end
          end
        endcase
      end
      if (state_q == swm_pkg::ST_IDLE) wheel_q <= '0;
      else if (state_q == swm_pkg::ST_A2) wheel_q <= wheel_q + 2'd1;
      if (state_q == swm_pkg::ST_FLP && (mode_q || !zero_q)) begin
        steer_q[wheel_q] <= swm_pkg::sat_store(c_flp);
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      swm_pkg::ST_IDLE: begin
        vx_q  <= cmd_i.cmd_vx;
        vy_q  <= cmd_i.cmd_vy;
        yaw_q <= cmd_i.cmd_yaw;
      end
      swm_pkg::ST_MLX: s_q <= {{(AW-32){steer_q[wheel_q][31]}}, steer_q[wheel_q]};
      swm_pkg::ST_MLY: wx_q <= w_sum[swm_pkg::WV_W-1:0];
      swm_pkg::ST_WY:  wy_q <= w_sum[swm_pkg::WV_W-1:0];
      swm_pkg::ST_CINIT: begin
        zero_q <= (wx_q == '0 && wy_q == '0);
        mag_q  <= '0;
        c_q    <= '0;
      end
      swm_pkg::ST_G1: acc_q <= {16'b0, prod_q} + swm_pkg::ACC_W'(1 << 23);
      swm_pkg::ST_G2: begin
        mag_q <= acc_sum[swm_pkg::MAG_W+23:24];
        c_q   <= c_ang;
      end
      swm_pkg::ST_UNW: begin
        c_q    <= c_unw;
        flag_q <= flag_unw;
      end
      swm_pkg::ST_FLP: begin
        c_q             <= c_flp;
        flip_q          <= flip_d;
        lost_q[wheel_q] <= !mode_q && !zero_q && !flag_q;
      end
      swm_pkg::ST_D1: acc_q <= {16'b0, prod_q};
      swm_pkg::ST_D2: begin
        drive_q[wheel_q] <= zero_q ? 32'd0 : swm_pkg::sat_out(!flip_q, acc_sum >> 24);
      end
      swm_pkg::ST_A1: acc_q <= {16'b0, prod_q};
      swm_pkg::ST_A2: srot_q[wheel_q] <= swm_pkg::sat_out(a_rot[AW-1], acc_sum >> RSH);
      default: begin
        acc_q <= acc_q;
      end
    endcase
    if (load_out) begin
      out_drive_q <= drive_q;
      out_steer_q <= srot_q;
      out_lost_q  <= lost_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.drive_rot0  = out_drive_q[0];
  assign res_o.drive_rot1  = out_drive_q[1];
  assign res_o.drive_rot2  = out_drive_q[2];
  assign res_o.drive_rot3  = out_drive_q[3];
  assign res_o.steer_rot0  = out_steer_q[0];
  assign res_o.steer_rot1  = out_steer_q[1];
  assign res_o.steer_rot2  = out_steer_q[2];
  assign res_o.steer_rot3  = out_steer_q[3];
  assign res_o.window_lost = out_lost_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command accepted while a command was in flight");

  a_wrap_no_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && mode_q) |-> (res_o.window_lost == 4'b0))
    else $error("window_lost set in single-wrap mode");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == swm_pkg::ST_DONE))
    else $error("result raised outside the completion step");

  a_cordic_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swm_pkg::ST_CORD && cord.done) |=> (state_q == swm_pkg::ST_G0))
    else $error("sequencer missed the rotation unit finishing");
`endif

endmodule

// ===== tb/sv/tb_swerve_module_command_top.sv =====
// Self-checking testbench for the swerve module command block.
`timescale 1ns / 1ps
module tb_swerve_module_command_top;

  localparam int AFB = 24;
  localparam longint ATAN_TAB [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
  localparam longint PI_L = 64'sd3373259426;
  localparam longint INV_GAIN = 64'sd10188014;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] yaw;
  } cmd_t;

  typedef struct packed {
    logic [3:0][31:0] drive;
    logic [3:0][31:0] steer;
    logic [3:0]       lost;
  } wheel_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  swm_cmd_if cmd_bus ();
  swm_res_if res_bus ();

  swerve_module_command_top #(.ANGLE_FRAC_BITS(AFB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_bus.sink), .res_o(res_bus.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic        mode_q;
  logic [31:0] lever_q [4];
  logic [31:0] speed_q;
  logic [31:0] angle_q;
  logic [31:0] heading_q [4];

  cmd_t       cmd_pending [$];
  wheel_res_t res_expected [$];
  int         errors = 0;
  int         send_idle = 15;
  int         recv_idle = 48;
  int         hold_off = 0;
  longint     cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_swerve_module_command_top: errors");
      $finish;
    end
  end

  function automatic longint sra(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint quarter(longint k);
    longint t;
    t = (k < 0 ? -k : k) * swm_pkg::HALF_PI_Q30_L;
    t = (t + (64'sd1 <<< (30 - AFB - 1))) >>> (30 - AFB);
    return k < 0 ? -t : t;
  endfunction

  function automatic longint q30_to_angle(longint z);
    return (z + (64'sd1 <<< (30 - AFB - 1))) >>> (30 - AFB);
  endfunction

  function automatic longint scale_mul(longint a, longint b, int n);
    longint p, q, pl;
    int m;
    m = n - 16;
    p = a * (b >> 16);
    q = a * (b & 64'hFFFF);
    pl = p & ((64'sd1 << m) - 1);
    return (p >> m) + (((pl << 16) + q) >> n);
  endfunction

  function automatic logic [31:0] clamp_out(bit neg, longint r);
    if (neg) return (r > 64'sh80000000) ? 32'h80000000 : 32'(-r);
    return (r > 64'sh7FFFFFFF) ? 32'h7FFFFFFF : 32'(r);
  endfunction

  function automatic logic [31:0] angle_to_rot(longint a);
    longint mag;
    mag = a < 0 ? -a : a;
    return clamp_out(a < 0, scale_mul(mag, longint'(angle_q), AFB + 8));
  endfunction

  function automatic logic [31:0] clamp_angle(longint a);
    if (a > 64'sh7FFFFFFF) a = 64'sh7FFFFFFF;
    if (a < -64'sh80000000) a = -64'sh80000000;
    return 32'(a);
  endfunction

  task automatic heading_and_speed(input longint x0, input longint y0,
                                   output longint ang, output longint mag);
    longint x, y, z, dx, dy;
    x = x0 * (64'sd1 << 20);
    y = y0 * (64'sd1 << 20);
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = y0 >= 0 ? PI_L : -PI_L;
    end
    for (int i = 0; i < 30; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    mag = ((x >>> 20) * INV_GAIN + (64'sd1 << 23)) >>> 24;
    if (y0 == 0) z = x0 > 0 ? 0 : PI_L;
    else if (x0 == 0) z = y0 > 0 ? swm_pkg::HALF_PI_Q30_L : -swm_pkg::HALF_PI_Q30_L;
    ang = q30_to_angle(z);
  endtask

  task automatic predict_wheels(input cmd_t c, output wheel_res_t r);
    longint lx, ly, wx, wy, s, h, mag;
    bit zero, tracked, flip;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      lx = longint'($signed(lever_q[i][31:16]));
      ly = longint'($signed(lever_q[i][15:0]));
      wx = longint'(c.vx) + sra(longint'(c.yaw) * lx, 12);
      wy = longint'(c.vy) + sra(longint'(c.yaw) * ly, 12);
      s = longint'($signed(heading_q[i]));
      h = 0;
      mag = 0;
      zero = (wx == 0 && wy == 0);
      tracked = 1'b1;
      flip = 1'b0;
      if (!zero) heading_and_speed(wx, wy, h, mag);
      if (!mode_q) begin
        if (zero) begin
          r.steer[i] = angle_to_rot(s);
          continue;
        end
        if (h > 0) begin
          if (-quarter(8) < s && s < -quarter(5)) h -= quarter(8);
          else if (-quarter(5) <= s && s < -quarter(1)) h -= quarter(4);
          else if (-quarter(1) <= s && s < quarter(3)) h = h;
          else if (quarter(3) <= s && s < quarter(7)) h += quarter(4);
          else tracked = 1'b0;
        end else if (h < 0) begin
          if (-quarter(7) < s && s < -quarter(3)) h -= quarter(4);
          else if (s < quarter(1)) begin
            if (s < -quarter(4)) tracked = 1'b0;
          end
          else if (s < quarter(5)) h += quarter(4);
          else if (s < quarter(8)) h += quarter(8);
          else tracked = 1'b0;
        end else begin
          if (-quarter(6) < s && s < -quarter(2)) h = -quarter(4);
          else if (s < quarter(2)) h = 0;
          else if (s < quarter(6)) h = quarter(4);
          else begin
            h = 0; tracked = 1'b0;
          end
        end
        if (!tracked) r.lost[i] = 1'b1;
      end else begin
        if (s > quarter(1) && h < 0) h += quarter(4);
        else if (s < -quarter(1) && h > 0) h -= quarter(4);
      end
      if (tracked) begin
        if (h - s > quarter(1)) begin
          h -= quarter(2); flip = 1'b1;
        end else if (h - s < -quarter(1)) begin
          h += quarter(2); flip = 1'b1;
        end
      end
      r.drive[i] = zero ? 32'd0 : clamp_out(!flip, scale_mul(mag, longint'(speed_q), 24));
      r.steer[i] = angle_to_rot(zero ? s : h);
      heading_q[i] = clamp_angle(h);
    end
  endtask

  // driver: predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    wheel_res_t r;
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
      cmd_bus.cmd_vx <= '0;
      cmd_bus.cmd_vy <= '0;
      cmd_bus.cmd_yaw <= '0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        predict_wheels({cmd_bus.cmd_vx, cmd_bus.cmd_vy, cmd_bus.cmd_yaw}, r);
        res_expected.push_back(r);
        void'(cmd_pending.pop_front());
      end
      if ((!cmd_bus.valid || cmd_bus.ready) && cmd_pending.size() > 0) begin
        if ($urandom_range(99) < send_idle) begin
          cmd_bus.valid <= 1'b0;
        end else begin
          // the head of the queue is always the next beat to offer
          cmd_bus.cmd_vx <= cmd_pending[0].vx;
          cmd_bus.cmd_vy <= cmd_pending[0].vy;
          cmd_bus.cmd_yaw <= cmd_pending[0].yaw;
          cmd_bus.valid <= 1'b1;
        end
      end else if (cmd_bus.valid && cmd_bus.ready) begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    wheel_res_t e, a;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        a.drive = {res_bus.drive_rot3, res_bus.drive_rot2, res_bus.drive_rot1,
                   res_bus.drive_rot0};
        a.steer = {res_bus.steer_rot3, res_bus.steer_rot2, res_bus.steer_rot1,
                   res_bus.steer_rot0};
        a.lost = res_bus.window_lost;
        if (res_expected.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat %h", $time, a);
        end else begin
          e = res_expected.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (e.drive[i] !== a.drive[i]) begin
              errors++;
              $display("%0t drive_rot%0d expected %h actual %h", $time, i, e.drive[i],
                       a.drive[i]);
            end
            if (e.steer[i] !== a.steer[i]) begin
              errors++;
              $display("%0t steer_rot%0d expected %h actual %h", $time, i, e.steer[i],
                       a.steer[i]);
            end
          end
          if (e.lost !== a.lost) begin
            errors++;
            $display("%0t window_lost expected %h actual %h", $time, e.lost, a.lost);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      swm_pkg::REG_MODE:  mode_q = val[0];
      swm_pkg::REG_SPEED: speed_q = val;
      swm_pkg::REG_ANGLE: angle_q = val;
      default: begin
        if (idx >= swm_pkg::REG_LEVER0 && idx <= swm_pkg::REG_LEVER3)
          lever_q[idx - swm_pkg::REG_LEVER0] = val;
      end
    endcase
  endtask

  task automatic drain;
    wait (cmd_pending.size() == 0 && !cmd_bus.valid);
    wait (res_expected.size() == 0);
    repeat (250) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h80000000;
      2: return 32'h7FFFFFFF;
      3: return 32'(int'($urandom_range(0, 262144)) - 131072);
      default: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic rand_levers(bit wide);
    for (int i = 0; i < 4; i++)
      write_reg(swm_pkg::REG_LEVER0 + 3'(i), wide ? $urandom :
                {16'(int'($urandom_range(0, 8192)) - 4096),
                 16'(int'($urandom_range(0, 8192)) - 4096)});
  endtask

  task automatic send(cmd_t c);
    cmd_pending.push_back(c);
  endtask

  task automatic random_phase(int n);
    cmd_t c;
    for (int k = 0; k < n; k++) begin
      c.vx = rand_word();
      c.vy = rand_word();
      c.yaw = ($urandom_range(3) == 0) ? rand_word() : 32'(int'($urandom_range(0, 131072)) - 65536);
      if ($urandom_range(9) == 0) begin
        c.vx = 0; c.vy = 0; c.yaw = 0;
      end
      send(c);
    end
  endtask

  initial begin
    mode_q = 1'b0;
    speed_q = 32'h01000000;
    angle_q = 32'h01000000;
    for (int i = 0; i < 4; i++) begin
      lever_q[i] = '0;
      heading_q[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(swm_pkg::REG_LEVER0, {16'sd1024, 16'sd1024});
    write_reg(swm_pkg::REG_LEVER0 + 3'd1, {16'sd1024, -16'sd1024});
    write_reg(swm_pkg::REG_LEVER0 + 3'd2, {-16'sd1024, 16'sd1024});
    write_reg(swm_pkg::REG_LEVER3, {-16'sd1024, -16'sd1024});
    // directed: zero, axes, extremes, turns that flip, a spin in place
    send('{0, 0, 0});
    send('{32'sh10000, 0, 0});
    send('{-32'sh10000, 0, 0});
    send('{0, 32'sh10000, 0});
    send('{0, -32'sh10000, 0});
    send('{0, 0, 32'sh10000});
    send('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    send('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    send('{32'sh80000000, 32'sh7FFFFFFF, 0});
    for (int k = 0; k < 10; k++) send('{32'(k * 20000 - 90000), 32'(30000 - k * 7000), 0});
    send('{-32'sh10000, 32'sd1, 0});
    send('{-32'sh10000, -32'sd1, 0});
    send('{0, 0, 0});
    drain();
    write_reg(swm_pkg::REG_MODE, 1'b1);
    write_reg(swm_pkg::REG_SPEED, 32'hFFFFFFFF);
    write_reg(swm_pkg::REG_ANGLE, 32'hFFFFFFFF);
    send('{0, 0, 0});
    send('{-32'sh10000, 32'sd5, 0});
    send('{-32'sh10000, -32'sd5, 0});
    drain();
    write_reg(swm_pkg::REG_SPEED, 32'h0);
    write_reg(swm_pkg::REG_ANGLE, 32'h0);
    rand_levers(1'b1);
    random_phase(40);
    drain();
    // random phases
    write_reg(swm_pkg::REG_MODE, 1'b0);
    write_reg(swm_pkg::REG_SPEED, 32'h01000000);
    write_reg(swm_pkg::REG_ANGLE, 32'h00A2F983);
    rand_levers(1'b0);
    random_phase(200);
    drain();
    send_idle = 48;
    recv_idle = 15;
    write_reg(swm_pkg::REG_MODE, 1'b1);
    write_reg(swm_pkg::REG_SPEED, $urandom);
    write_reg(swm_pkg::REG_ANGLE, $urandom);
    rand_levers(1'b0);
    random_phase(100);
    hold_off = 2000;
    random_phase(100);
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_reg(swm_pkg::REG_MODE, 1'b0);
    write_reg(swm_pkg::REG_SPEED, 32'h00800000);
    write_reg(swm_pkg::REG_ANGLE, 32'h01000000);
    rand_levers($urandom_range(1));
    random_phase(250);
    drain();
    if (errors == 0) $display("tb_swerve_module_command_top: clean");
    else $display("tb_swerve_module_command_top: errors");
    $finish;
  end

endmodule
